// ===== src/plf_pkg.sv =====
// Shared types and constants of the preamble length deframer.
`default_nettype none

package plf_pkg;

	localparam int unsigned SYNC_LEN = 16;
	localparam int unsigned LIMIT_W = 21;
	localparam int unsigned LEN_W = 32;

	localparam logic [7:0] SYNC_PATTERN [SYNC_LEN] = '{
		8'h50, 8'h49, 8'h4E, 8'h47, 8'h27, 8'h2B, 8'h3A, 8'hD8,
		8'h74, 8'h2A, 8'h1C, 8'h33, 8'hE9, 8'hB0, 8'h73, 8'hB1
	};

	localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RESET = 21'd65552;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_EMPTY   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         out_byte;
		logic [LIMIT_W-1:0] skipped;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

// ===== src/preamble_length_deframer.sv =====
// An accepted byte waits in the input register; its result, if any, goes to the
// result register. One byte per cycle is taken unless out_stall holds both
// registers full; they decouple the sides, so a byte is taken while a result waits.
// Reset (arst_n low) returns to hunting with all counters cleared and the
// search limit at 65552; no result is held after reset.
`default_nettype none

module preamble_length_deframer (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [plf_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [7:0]                   in_byte,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   kind,
	output logic [7:0]                   out_byte,
	output logic [plf_pkg::LIMIT_W-1:0]  skipped,
	output logic                         last
);

	logic [plf_pkg::LIMIT_W-1:0] search_limit_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        valid_s2;
	plf_pkg::result_t            res_s2;

	logic                        advance;
	logic                        step_valid;
	plf_pkg::result_t            step_res;

	// The held byte is processed once the result register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	plf_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.data         (byte_s1),
		.search_limit (search_limit_q),
		.res_valid    (step_valid),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_limit_q <= plf_pkg::SEARCH_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			search_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && step_valid) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid = valid_s2;
	assign kind      = res_s2.kind;
	assign out_byte  = res_s2.out_byte;
	assign skipped   = res_s2.skipped;
	assign last      = res_s2.last;

`ifndef ASSERT_OFF
	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !valid_s2 |=> !out_valid)
		else $error("result appeared without a byte being processed");

	a_skip_only_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != plf_pkg::KIND_HEADER |-> skipped == '0)
		else $error("skip count set on a result that is not a header");

	a_byte_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != plf_pkg::KIND_PAYLOAD |-> out_byte == '0 && !last)
		else $error("payload fields set on a result that is not payload");

	a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// ===== src/plf_step.sv =====
// Deframer state registers and the per-byte update logic.
`default_nettype none

module plf_step (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           fire,
	input  wire  [7:0]                    data,
	input  wire  [plf_pkg::LIMIT_W-1:0]   search_limit,
	output logic                          res_valid,
	output plf_pkg::result_t              res
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t                        phase_q, phase_n;
	logic [3:0]                    pos_q, pos_n;
	logic [plf_pkg::LIMIT_W-1:0]   count_q, count_n;
	logic [plf_pkg::LEN_W-1:0]     len_q, len_n;
	logic [1:0]                    seen_q, seen_n;
	logic [plf_pkg::LEN_W-1:0]     remain_q, remain_n;

	logic [plf_pkg::LEN_W-1:0]     len_merged;
	logic [plf_pkg::LEN_W-1:0]     remain_dec;
	logic [plf_pkg::LIMIT_W-1:0]   count_inc;
	logic                          hit;

	always_comb begin
		len_merged = len_q | ({24'd0, data} << {seen_q, 3'b000});
		remain_dec = remain_q - 32'd1;
		count_inc  = count_q + 21'd1;
		hit        = (data == plf_pkg::SYNC_PATTERN[pos_q]);

		phase_n   = phase_q;
		pos_n     = pos_q;
		count_n   = count_q;
		len_n     = len_q;
		seen_n    = seen_q;
		remain_n  = remain_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_LENGTH: begin
				seen_n = seen_q + 2'd1;
				len_n  = len_merged;
				if (seen_q == 2'd3) begin
					len_n  = '0;
					seen_n = '0;
					if (len_merged == '0) begin
						phase_n   = PH_HUNT;
						pos_n     = '0;
						count_n   = '0;
						res_valid = 1'b1;
						res.kind  = plf_pkg::KIND_EMPTY;
					end else begin
						remain_n = len_merged;
						phase_n  = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				remain_n     = remain_dec;
				res_valid    = 1'b1;
				res.kind     = plf_pkg::KIND_PAYLOAD;
				res.out_byte = data;
				res.last     = (remain_dec == '0);
				if (remain_dec == '0) begin
					phase_n = PH_HUNT;
					pos_n   = '0;
					count_n = '0;
					len_n   = '0;
					seen_n  = '0;
				end
			end
			default: begin
				// Hunting; a mismatching byte is not retried as a first byte.
				if (hit && pos_q == 4'd15) begin
					phase_n     = PH_LENGTH;
					pos_n       = '0;
					count_n     = '0;
					len_n       = '0;
					seen_n      = '0;
					res_valid   = 1'b1;
					res.kind    = plf_pkg::KIND_HEADER;
					res.skipped = (count_inc >= 21'd16) ? count_inc - 21'd16 : '0;
				end else begin
					pos_n   = hit ? pos_q + 4'd1 : 4'd0;
					count_n = count_inc;
					if (count_inc >= search_limit) begin
						phase_n   = PH_HUNT;
						pos_n     = '0;
						count_n   = '0;
						len_n     = '0;
						seen_n    = '0;
						res_valid = 1'b1;
						res.kind  = plf_pkg::KIND_TIMEOUT;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			pos_q    <= '0;
			count_q  <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			remain_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			count_q  <= count_n;
			len_q    <= len_n;
			seen_q   <= seen_n;
			remain_q <= remain_n;
		end
	end

endmodule

`default_nettype wire
